FILE: src/wsd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared constants and types for the work-stealing deque.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int DEPTH     = 1024;
    localparam int ITEM_BITS = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int PTR_W     = IDX_W + 1;   // pointers wrap at twice the depth
    localparam int OP_W      = 2;
    localparam int OCC_W     = PTR_W;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming word
        logic exec;      // apply the operation to pointers and ring
        logic out_load;  // move the result into the output register
    } cmd_t;

endpackage

FILE: src/work_stealing_deque.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// work_stealing_deque
// Bounded double-ended task queue in a ring: push/pop at bottom, steal at top.
// ---------------------------------------------------------------------------
// Each operation passes from acceptance to its result being loaded into the
// output register through capture, one ring access with registered read
// data, and result load; the sequencer handles one word at a time, so a new
// word is not accepted until the previous result has been loaded. A new word
// may be accepted while the previous result is still waiting on the output.
// Push fails when DEPTH items are held, pop and steal fail on an empty ring
// and then return zero. The ring needs no clearing after reset: only entries
// holding live items are ever read.
module work_stealing_deque
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wsd_pkg::OP_W-1:0]      op,
    input  logic [wsd_pkg::ITEM_BITS-1:0] push_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [wsd_pkg::ITEM_BITS-1:0] item_out,
    output logic [wsd_pkg::OCC_W-1:0]     occupancy
);

    wsd_pkg::cmd_t cmd;

    wsd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    wsd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .push_item (push_item),
        .ok        (ok),
        .item_out  (item_out),
        .occupancy (occupancy)
    );

endmodule

FILE: src/wsd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_ctrl
// Sequencer: accept, execute, load result; owns the output valid flag.
// ---------------------------------------------------------------------------
module wsd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output wsd_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    // output register can take a new word if empty or being drained now
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted word did not start execution");

    a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_LOAD))
        else $error("execute not followed by result load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: src/wsd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_datapath
// Ring memory, top and bottom pointers, and the output register.
// ---------------------------------------------------------------------------
module wsd_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsd_pkg::cmd_t                 cmd,
    input  logic [wsd_pkg::OP_W-1:0]      op,
    input  logic [wsd_pkg::ITEM_BITS-1:0] push_item,
    output logic                          ok,
    output logic [wsd_pkg::ITEM_BITS-1:0] item_out,
    output logic [wsd_pkg::OCC_W-1:0]     occupancy
);

    logic [wsd_pkg::ITEM_BITS-1:0] ring_mem [wsd_pkg::DEPTH];

    logic [wsd_pkg::OP_W-1:0]      op_reg;
    logic [wsd_pkg::ITEM_BITS-1:0] item_reg;
    logic [wsd_pkg::PTR_W-1:0]     top_reg;
    logic [wsd_pkg::PTR_W-1:0]     top_next;
    logic [wsd_pkg::PTR_W-1:0]     bot_reg;
    logic [wsd_pkg::PTR_W-1:0]     bot_next;
    logic                          ok_reg;
    logic                          ok_next;
    logic                          take_reg;
    logic                          take_next;
    logic [wsd_pkg::ITEM_BITS-1:0] rd_data_reg;
    logic                          ok_out_reg;
    logic [wsd_pkg::ITEM_BITS-1:0] item_out_reg;
    logic [wsd_pkg::OCC_W-1:0]     occ_out_reg;

    logic [wsd_pkg::PTR_W-1:0]     occ;
    logic [wsd_pkg::PTR_W-1:0]     bot_dec;
    logic [wsd_pkg::PTR_W-1:0]     top_inc;
    logic                          empty;
    logic                          full;
    logic                          wr_en;
    logic                          rd_en;
    logic [wsd_pkg::IDX_W-1:0]     rd_idx;

    // pointers wrap naturally at 2*DEPTH
    assign occ     = bot_reg - top_reg;
    assign bot_dec = bot_reg - wsd_pkg::PTR_W'(1);
    assign top_inc = top_reg + wsd_pkg::PTR_W'(1);
    assign empty   = (occ == '0);
    assign full    = (occ == wsd_pkg::PTR_W'(wsd_pkg::DEPTH));

    always_comb
    begin
        top_next  = top_reg;
        bot_next  = bot_reg;
        ok_next   = 1'b0;
        take_next = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = top_reg[wsd_pkg::IDX_W-1:0];
        case (op_reg)
            wsd_pkg::OP_PUSH:
            begin
                if (!full)
                begin
                    wr_en    = cmd.exec;
                    bot_next = bot_reg + wsd_pkg::PTR_W'(1);
                    ok_next  = 1'b1;
                end
            end
            wsd_pkg::OP_POP:
            begin
                rd_idx = bot_dec[wsd_pkg::IDX_W-1:0];
                if (!empty)
                begin
                    rd_en     = cmd.exec;
                    ok_next   = 1'b1;
                    take_next = 1'b1;
                    // last item: collapse both pointers one past old top
                    if (occ == wsd_pkg::PTR_W'(1))
                    begin
                        top_next = top_inc;
                        bot_next = top_inc;
                    end
                    else
                    begin
                        bot_next = bot_dec;
                    end
                end
            end
            wsd_pkg::OP_STEAL:
            begin
                if (!empty)
                begin
                    rd_en     = cmd.exec;
                    ok_next   = 1'b1;
                    take_next = 1'b1;
                    top_next  = top_inc;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[bot_reg[wsd_pkg::IDX_W-1:0]] <= item_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            item_reg <= push_item;
        end
        if (cmd.exec)
        begin
            ok_reg   <= ok_next;
            take_reg <= take_next;
        end
        if (cmd.out_load)
        begin
            ok_out_reg   <= ok_reg;
            item_out_reg <= take_reg ? rd_data_reg : '0;
            occ_out_reg  <= wsd_pkg::OCC_W'(occ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bot_reg <= '0;
        end
        else if (cmd.exec)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    assign ok        = ok_out_reg;
    assign item_out  = item_out_reg;
    assign occupancy = occ_out_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= wsd_pkg::PTR_W'(wsd_pkg::DEPTH))
        else $error("occupancy beyond ring depth");

endmodule
